FILE: hw/rtl/ubx_pkg.sv
// Shared types, constants and helpers for the frame parser and navigation decoder.
// Depends on nothing; every other file in the block imports it.
package ubx_pkg;

	localparam int MAX_PAYLOAD = 256;
	localparam int CAP_LEN     = 24;
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int CAP_IDX_W   = $clog2(CAP_LEN);

	localparam logic [7:0] SYNC1_BYTE = 8'hB5;
	localparam logic [7:0] SYNC2_BYTE = 8'h62;

	localparam logic [15:0] KEY_POSLLH  = 16'h0102;
	localparam logic [15:0] KEY_ODO     = 16'h0109;
	localparam logic [15:0] KEY_TIMEUTC = 16'h0121;
	localparam logic [15:0] KEY_SAT     = 16'h0135;
	localparam logic [15:0] KEY_VELNED  = 16'h0112;
	localparam logic [15:0] KEY_NAK     = 16'h0500;
	localparam logic [15:0] KEY_ACK     = 16'h0501;

	localparam logic [4:0] HOUR_OFFSET_RST    = 5'd17;
	localparam logic [7:0] SATS_THRESHOLD_RST = 8'd10;

	localparam logic [2:0] REG_HOUR_OFFSET    = 3'd0;
	localparam logic [2:0] REG_SATS_THRESHOLD = 3'd4;

	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam int FLAG_NEW   = 0;
	localparam int FLAG_VALID = 1;
	localparam int FLAG_ACK   = 2;

	typedef enum logic [2:0] {
		KIND_POS  = 3'd0,
		KIND_ODO  = 3'd1,
		KIND_UTC  = 3'd2,
		KIND_SAT  = 3'd3,
		KIND_VEL  = 3'd4,
		KIND_NAK  = 3'd5,
		KIND_ACK  = 3'd6,
		KIND_NONE = 3'd7
	} msg_kind_t;

	typedef enum logic [1:0] {
		CMD_DECODE  = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
		logic [2:0] clear_mask;
	} item_t;

	typedef struct packed {
		logic [2:0]  msg_kind;
		logic [31:0] value_a;
		logic [31:0] latitude;
		logic [31:0] time_of_week;
		logic [31:0] elapsed_ms;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  local_hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [2:0]  status_flags;
	} result_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		msg_kind_t                 msg;
		logic [2:0]                mask;
		logic [CAP_LEN-1:0][7:0]   store;
	} cmd_t;

	typedef struct packed {
		logic [4:0] hour_offset;
		logic [7:0] sats_threshold;
	} cfg_t;

	function automatic msg_kind_t classify(input logic [15:0] key);
		msg_kind_t k;
		case (key)
			KEY_POSLLH:  k = KIND_POS;
			KEY_ODO:     k = KIND_ODO;
			KEY_TIMEUTC: k = KIND_UTC;
			KEY_SAT:     k = KIND_SAT;
			KEY_VELNED:  k = KIND_VEL;
			KEY_NAK:     k = KIND_NAK;
			KEY_ACK:     k = KIND_ACK;
			default:     k = KIND_NONE;
		endcase
		return k;
	endfunction

	// (hour + offset) mod 24 by a reciprocal estimate that is low by at most one.
	function automatic logic [7:0] hour_mod24(input logic [7:0] h, input logic [4:0] o);
		logic [8:0]  s;
		logic [13:0] p;
		logic [3:0]  q;
		logic [8:0]  r;
		s = {1'b0, h} + {4'b0, o};
		p = s * 14'd21;
		q = p[12:9];
		r = s - 9'(q * 9'd24);
		if (r >= 9'd24) begin
			r = r - 9'd24;
		end
		return r[7:0];
	endfunction

endpackage

FILE: hw/rtl/ubx_front.sv
// Front end: sync hunt, header and length parsing, payload capture.
// Depends on ubx_pkg; emits commands for the back end through the queue.
module ubx_front
	import ubx_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  item_t item,
	output logic  cmd_push,
	output cmd_t  cmd
);

	typedef enum logic [7:0] {
		PH_SYNC1   = 8'b0000_0001,
		PH_SYNC2   = 8'b0000_0010,
		PH_CLASS   = 8'b0000_0100,
		PH_ID      = 8'b0000_1000,
		PH_LEN1    = 8'b0001_0000,
		PH_LEN2    = 8'b0010_0000,
		PH_PAYLOAD = 8'b0100_0000,
		PH_DECODE  = 8'b1000_0000
	} phase_t;

	phase_t                  phase_q;
	logic [7:0]              class_q;
	logic [7:0]              id_q;
	logic [15:0]             remain_q;
	logic [CNT_W-1:0]        captured_q;
	logic [CAP_LEN-1:0][7:0] store_q;
	logic [15:0]             remain_dec;
	msg_kind_t               kind;

	assign remain_dec = remain_q - 16'd1;
	assign kind       = classify({class_q, id_q});

	always_comb begin
		cmd_push  = 1'b0;
		cmd.kind  = CMD_NOP;
		cmd.msg   = kind;
		cmd.mask  = item.clear_mask;
		cmd.store = store_q;
		if (take) begin
			case (item.op)
				OP_BYTE: begin
					if (phase_q == PH_DECODE && kind != KIND_NONE) begin
						cmd_push = 1'b1;
						cmd.kind = CMD_DECODE;
					end
				end
				OP_RESTART: begin
					cmd_push = 1'b1;
					cmd.kind = CMD_RESTART;
				end
				OP_CLEAR: begin
					cmd_push = 1'b1;
					cmd.kind = CMD_CLEAR;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC1;
			class_q    <= '0;
			id_q       <= '0;
			remain_q   <= '0;
			captured_q <= '0;
			store_q    <= '0;
		end else if (take && item.op == OP_BYTE) begin
			case (phase_q)
				PH_SYNC1: phase_q <= (item.rx_byte == SYNC1_BYTE) ? PH_SYNC2 : PH_SYNC1;
				PH_SYNC2: phase_q <= (item.rx_byte == SYNC2_BYTE) ? PH_CLASS : PH_SYNC1;
				PH_CLASS: begin
					class_q <= item.rx_byte;
					phase_q <= PH_ID;
				end
				PH_ID: begin
					id_q    <= item.rx_byte;
					phase_q <= PH_LEN1;
				end
				PH_LEN1: begin
					remain_q <= {8'd0, item.rx_byte};
					phase_q  <= PH_LEN2;
				end
				PH_LEN2: begin
					remain_q   <= {item.rx_byte, remain_q[7:0]};
					captured_q <= '0;
					phase_q    <= PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (captured_q >= CNT_W'(MAX_PAYLOAD)) begin
						phase_q <= PH_SYNC1;
					end else begin
						if (captured_q < CNT_W'(CAP_LEN)) begin
							store_q[captured_q[CAP_IDX_W-1:0]] <= item.rx_byte;
						end
						captured_q <= captured_q + CNT_W'(1);
						remain_q   <= remain_dec;
						if (remain_dec == 16'd0) begin
							phase_q <= PH_DECODE;
						end
					end
				end
				PH_DECODE: phase_q <= PH_SYNC1;
				default:   phase_q <= PH_SYNC1;
			endcase
		end
	end

endmodule

FILE: hw/rtl/ubx_cmdq.sv
// Two-entry command queue between the front end and the back end.
// Depends on ubx_pkg for the command type.
module ubx_cmdq
	import ubx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	input  logic rd,
	output cmd_t rdata,
	output logic full,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

FILE: hw/rtl/ubx_back.sv
// Back end: message decode, status flags, time reference and result register.
// Depends on ubx_pkg; consumes commands from the queue.
module ubx_back
	import ubx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	logic [2:0]  flags_q;
	logic [31:0] tref_q;
	logic        res_valid_q;
	result_t     res_q;

	result_t     r;
	logic [2:0]  flags_nx;
	logic [31:0] tref_nx;
	logic        emit;
	logic [31:0] tow;
	logic [31:0] tref_eff;
	logic        slot_free;

	assign slot_free = !res_valid_q || pop;
	assign cmd_pop   = cmd_valid && slot_free;
	assign tow       = {cmd.store[3], cmd.store[2], cmd.store[1], cmd.store[0]};
	assign tref_eff  = (tref_q == 32'd0) ? tow : tref_q;

	always_comb begin
		r        = '0;
		flags_nx = flags_q;
		tref_nx  = tref_q;
		emit     = 1'b0;
		r.msg_kind = cmd.msg;
		case (cmd.kind)
			CMD_RESTART: tref_nx = 32'd0;
			CMD_CLEAR:   flags_nx = flags_q & ~cmd.mask;
			CMD_DECODE: begin
				emit = 1'b1;
				case (cmd.msg)
					KIND_POS: begin
						r.value_a      = {cmd.store[7], cmd.store[6], cmd.store[5], cmd.store[4]};
						r.latitude     = {cmd.store[11], cmd.store[10], cmd.store[9],
							cmd.store[8]};
						r.time_of_week = tow;
						r.elapsed_ms   = tow - tref_eff;
						tref_nx        = tref_eff;
						flags_nx[FLAG_NEW] = 1'b1;
					end
					KIND_ODO: begin
						r.value_a = {cmd.store[11], cmd.store[10], cmd.store[9], cmd.store[8]};
						flags_nx[FLAG_NEW] = 1'b1;
					end
					KIND_UTC: begin
						r.year       = {cmd.store[13], cmd.store[12]};
						r.month      = cmd.store[14];
						r.day        = cmd.store[15];
						r.local_hour = hour_mod24(cmd.store[16], cfg.hour_offset);
						r.minute     = cmd.store[17];
						r.second     = cmd.store[18];
						flags_nx[FLAG_NEW] = 1'b1;
					end
					KIND_SAT: begin
						r.value_a = {24'd0, cmd.store[5]};
						if (cmd.store[5] >= cfg.sats_threshold) begin
							flags_nx[FLAG_VALID] = 1'b1;
						end
						flags_nx[FLAG_NEW] = 1'b1;
					end
					KIND_VEL: begin
						r.value_a = {cmd.store[23], cmd.store[22], cmd.store[21],
							cmd.store[20]};
						flags_nx[FLAG_NEW] = 1'b1;
					end
					KIND_NAK: flags_nx[FLAG_ACK] = 1'b0;
					KIND_ACK: flags_nx[FLAG_ACK] = 1'b1;
					default:  emit = 1'b0;
				endcase
				r.status_flags = flags_nx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			tref_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				flags_q <= flags_nx;
				tref_q  <= tref_nx;
			end
			if (slot_free) begin
				res_valid_q <= cmd_pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && emit) begin
			res_q <= r;
		end
	end

	assign result = res_q;
	assign empty  = !res_valid_q;

endmodule

FILE: hw/rtl/ubx_frame_parser_nav_decode.sv
// Frame parser and navigation decoder: one byte or command beat per cycle while the
// command queue has room. A frame's result reaches the result ports once the byte that
// follows its payload is taken: that byte writes its command into the queue, and the back
// end then decodes the command into the result register once that register is free.
// The front end's byte state machine takes a beat every cycle unless the queue is full.
// Asynchronous active-low reset clears parser state, flags, time reference and queues,
// and loads the configuration registers with hour offset 17 and threshold 10.
module ubx_frame_parser_nav_decode
	import ubx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  item_t       item,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers, written through the APB-style port.
	cfg_t cfg_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hour_offset    <= HOUR_OFFSET_RST;
			cfg_q.sats_threshold <= SATS_THRESHOLD_RST;
		end else if (cfg_wr) begin
			case ({paddr[2], 2'b00})
				REG_HOUR_OFFSET:    cfg_q.hour_offset    <= pwdata[4:0];
				REG_SATS_THRESHOLD: cfg_q.sats_threshold <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case ({paddr[2], 2'b00})
			REG_HOUR_OFFSET:    prdata = {27'd0, cfg_q.hour_offset};
			REG_SATS_THRESHOLD: prdata = {24'd0, cfg_q.sats_threshold};
			default:            prdata = '0;
		endcase
	end

	// An input beat is taken whenever the command queue has room, so a full
	// queue is the only thing that holds back the front end.
	logic take;
	logic q_push;
	cmd_t q_wdata;
	logic q_pop;
	cmd_t q_rdata;
	logic q_full;
	logic q_empty;

	assign full = q_full;
	assign take = push && !q_full;

	ubx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.cmd_push (q_push),
		.cmd      (q_wdata)
	);

	ubx_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// The back end drains the queue whenever its result register is free or
	// being emptied in the same cycle.
	ubx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (!q_empty),
		.cmd       (q_rdata),
		.cmd_pop   (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	// The queue is never written while full.
	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !q_push)
		else $error("command queue written while full");

	// A waiting command with a free result register is taken at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && (empty || pop)) |-> q_pop)
		else $error("back end stalled with room for a result");

	// A result that is not popped stays for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("pending result lost");

endmodule
